// File: design/udmf_pkg.sv
// Package for the UDP destination match filter: packet kinds, the command
// item passed from parser to matcher, and the protocol constants.
// No dependencies.
package udmf_pkg;

    localparam int UDMF_TABLE_ENTRIES = 64;
    localparam int UDMF_QUEUE_DEPTH   = 4;

    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] ETH_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [6:0]  ETH_HDR_LEN = 7'd14;
    localparam logic [5:0]  POS_LIMIT   = 6'd63;

    typedef enum logic [2:0] {
        KIND_NOT_IP   = 3'd0,
        KIND_V4_OTHER = 3'd1,
        KIND_V6_OTHER = 3'd2,
        KIND_V4_UDP   = 3'd3,
        KIND_V6_UDP   = 3'd4,
        KIND_TRUNC    = 3'd5
    } kind_t;

    // One queued command: a table write or a frame-end lookup.
    typedef struct packed {
        logic        is_write;
        logic [5:0]  slot;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic        is_v6;
        logic        key_valid;
        kind_t       kind;
    } cmd_t;

endpackage

// File: design/udmf_parser.sv
// Front end: accepts items, tracks frame offsets, captures header fields and
// emits one command per table write or frame end. Depends on udmf_pkg.
module udmf_parser
    import udmf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_accept,
    input  logic        op,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [5:0]  slot,
    input  logic [63:0] key_addr_high,
    input  logic [63:0] key_addr_low,
    input  logic [15:0] key_port,
    input  logic        key_is_v6,
    input  logic        key_valid,
    output logic        push,
    output cmd_t        push_cmd
);

    logic [5:0]  pos_reg,   pos_next;
    logic [15:0] etype_reg, etype_next;
    logic [7:0]  proto_reg, proto_next;
    logic [63:0] ahigh_reg, ahigh_next;
    logic [63:0] alow_reg,  alow_next;
    logic [15:0] port_reg,  port_next;

    logic        is_v4;
    logic        is_v6;
    logic [6:0]  count;
    kind_t       kind;

    assign is_v4 = (etype_reg == ETH_IPV4);
    assign is_v6 = (etype_reg == ETH_IPV6);
    assign count = {1'b0, pos_reg} + 7'd1;

    // Field capture for the current byte.
    always_comb begin
        etype_next = etype_reg;
        proto_next = proto_reg;
        ahigh_next = ahigh_reg;
        alow_next  = alow_reg;
        port_next  = port_reg;
        if (pos_reg == 6'd12) begin
            etype_next = {data_byte, 8'h00};
        end else if (pos_reg == 6'd13) begin
            etype_next = etype_reg | {8'h00, data_byte};
        end else if (is_v4) begin
            if (pos_reg == 6'd23) proto_next = data_byte;
            if (pos_reg == 6'd36) port_next = {data_byte, 8'h00};
            if (pos_reg == 6'd37) port_next = port_reg | {8'h00, data_byte};
            for (int j = 0; j < 4; j++) begin
                if (pos_reg == 6'(30 + j))
                    ahigh_next[63 - 8*j -: 8] = ahigh_reg[63 - 8*j -: 8] | data_byte;
            end
        end else if (is_v6) begin
            if (pos_reg == 6'd20) proto_next = data_byte;
            if (pos_reg == 6'd56) port_next = {data_byte, 8'h00};
            if (pos_reg == 6'd57) port_next = port_reg | {8'h00, data_byte};
            for (int j = 0; j < 8; j++) begin
                if (pos_reg == 6'(38 + j))
                    ahigh_next[63 - 8*j -: 8] = ahigh_reg[63 - 8*j -: 8] | data_byte;
                if (pos_reg == 6'(46 + j))
                    alow_next[63 - 8*j -: 8] = alow_reg[63 - 8*j -: 8] | data_byte;
            end
        end
        pos_next = (pos_reg < POS_LIMIT) ? pos_reg + 6'd1 : pos_reg;
    end

    // Classification on the updated header state.
    always_comb begin
        if (count < ETH_HDR_LEN) begin
            kind = KIND_TRUNC;
        end else if (etype_next == ETH_IPV4) begin
            if (count < 7'd24)                kind = KIND_TRUNC;
            else if (proto_next != PROTO_UDP) kind = KIND_V4_OTHER;
            else if (count < 7'd38)           kind = KIND_TRUNC;
            else                              kind = KIND_V4_UDP;
        end else if (etype_next == ETH_IPV6) begin
            if (count < 7'd21)                kind = KIND_TRUNC;
            else if (proto_next != PROTO_UDP) kind = KIND_V6_OTHER;
            else if (count < 7'd58)           kind = KIND_TRUNC;
            else                              kind = KIND_V6_UDP;
        end else begin
            kind = KIND_NOT_IP;
        end
    end

    always_comb begin
        push = in_accept && (op || last_byte);
        push_cmd.is_write = op;
        push_cmd.slot     = slot;
        push_cmd.kind     = kind;
        if (op) begin
            push_cmd.addr_high = key_addr_high;
            push_cmd.addr_low  = key_addr_low;
            push_cmd.port      = key_port;
            push_cmd.is_v6     = key_is_v6;
            push_cmd.key_valid = key_valid;
        end else begin
            push_cmd.addr_high = ahigh_next;
            push_cmd.addr_low  = alow_next;
            push_cmd.port      = port_next;
            push_cmd.is_v6     = (kind == KIND_V6_UDP);
            push_cmd.key_valid = (kind == KIND_V4_UDP) || (kind == KIND_V6_UDP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            etype_reg <= '0;
            proto_reg <= '0;
            ahigh_reg <= '0;
            alow_reg  <= '0;
            port_reg  <= '0;
        end else if (in_accept && !op) begin
            if (last_byte) begin
                pos_reg   <= '0;
                etype_reg <= '0;
                proto_reg <= '0;
                ahigh_reg <= '0;
                alow_reg  <= '0;
                port_reg  <= '0;
            end else begin
                pos_reg   <= pos_next;
                etype_reg <= etype_next;
                proto_reg <= proto_next;
                ahigh_reg <= ahigh_next;
                alow_reg  <= alow_next;
                port_reg  <= port_next;
            end
        end
    end

endmodule

// File: design/udmf_queue.sv
// Short command queue between parser and matcher.
// Depends on udmf_pkg for the command type and depth.
module udmf_queue
    import udmf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(UDMF_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(UDMF_QUEUE_DEPTH + 1);

    cmd_t             mem [UDMF_QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_W'(UDMF_QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = mem[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wptr_next = do_push ? wptr_reg + PTR_W'(1) : wptr_reg;
        rptr_next = do_pop  ? rptr_reg + PTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + CNT_W'(1);
        if (!do_push && do_pop) cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wptr_reg] <= push_cmd;
    end

endmodule

// File: design/udmf_matcher.sv
// Back end: holds the match table, applies writes in order, and runs the
// lookup as a compare stage then a priority-encode/output stage. Uses udmf_pkg.
module udmf_matcher
    import udmf_pkg::*;
#(
    parameter int TABLE_ENTRIES = UDMF_TABLE_ENTRIES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_verdict,
    output logic [2:0] m_packet_kind,
    output logic [5:0] m_matched_slot
);

    logic                     ent_valid_reg [TABLE_ENTRIES];
    logic [63:0]              ent_ahigh [TABLE_ENTRIES];
    logic [63:0]              ent_alow  [TABLE_ENTRIES];
    logic [15:0]              ent_port  [TABLE_ENTRIES];
    logic                     ent_v6    [TABLE_ENTRIES];

    logic                     s1_valid_reg;
    logic [TABLE_ENTRIES-1:0] s1_match_reg, s1_match_next;
    kind_t                    s1_kind_reg;

    logic                     out_valid_reg;
    logic                     out_verdict_reg;
    kind_t                    out_kind_reg;
    logic [5:0]               out_slot_reg;

    logic                     out_load;
    logic                     s1_load;
    logic                     do_write;
    logic                     do_lookup;
    logic                     any_match;
    logic [5:0]               first_slot;

    assign out_load  = !out_valid_reg || m_ready;
    assign s1_load   = !s1_valid_reg || out_load;
    assign do_write  = cmd_valid && cmd.is_write;
    assign do_lookup = cmd_valid && !cmd.is_write && s1_load;
    assign cmd_pop   = do_write || do_lookup;

    // Parallel compare against every entry.
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            s1_match_next[i] = cmd.key_valid && ent_valid_reg[i] &&
                               (ent_v6[i] == cmd.is_v6) &&
                               (ent_ahigh[i] == cmd.addr_high) &&
                               (ent_alow[i] == cmd.addr_low) &&
                               (ent_port[i] == cmd.port);
        end
    end

    // Lowest matching index wins.
    always_comb begin
        any_match  = |s1_match_reg;
        first_slot = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (s1_match_reg[i]) first_slot = 6'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) ent_valid_reg[i] <= 1'b0;
        end else if (do_write) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if ({26'd0, cmd.slot} == 32'(i)) ent_valid_reg[i] <= cmd.key_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write && cmd.key_valid) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if ({26'd0, cmd.slot} == 32'(i)) begin
                    ent_ahigh[i] <= cmd.addr_high;
                    ent_alow[i]  <= cmd.addr_low;
                    ent_port[i]  <= cmd.port;
                    ent_v6[i]    <= cmd.is_v6;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_load)  s1_valid_reg  <= do_lookup;
            if (out_load) out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load && do_lookup) begin
            s1_match_reg <= s1_match_next;
            s1_kind_reg  <= cmd.kind;
        end
        if (out_load && s1_valid_reg) begin
            out_verdict_reg <= any_match;
            out_kind_reg    <= s1_kind_reg;
            out_slot_reg    <= first_slot;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_verdict      = out_verdict_reg;
    assign m_packet_kind  = out_kind_reg;
    assign m_matched_slot = out_slot_reg;

endmodule

// File: design/udp_destination_match_filter.sv
// UDP destination exact-match filter, top level: parser front end, command
// queue and table matcher. Depends on udmf_pkg and the udmf_* modules.
//
// Usage: feed an Ethernet frame one byte per item (s_op = 0, s_last_byte on
// the final byte) and table updates as separate items (s_op = 1, s_slot and
// the key fields; s_key_valid = 0 removes an entry). The block accepts one
// item per clock when the result side is not backed up. Each frame gives
// exactly one result when its last byte is taken: m_packet_kind, and
// m_verdict = 1 (drop) when an IPv4/IPv6 UDP frame's family, destination
// address and port equal a valid table entry, with m_matched_slot the lowest
// such entry. The last byte's lookup command is written into the queue,
// then loaded into the compare stage and then into the output register,
// which drives m_valid. Table writes
// and lookups are applied in arrival order, so a lookup sees every write
// that came before it. The queue (four commands) decouples the parser from
// the matcher, so a stalled result port stops input only once it fills.
// Valid bits of the table clear at reset; no clearing pass is needed.
module udp_destination_match_filter
    import udmf_pkg::*;
#(
    parameter int TABLE_ENTRIES = UDMF_TABLE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic [5:0]  s_slot,
    input  logic [63:0] s_key_addr_high,
    input  logic [63:0] s_key_addr_low,
    input  logic [15:0] s_key_port,
    input  logic        s_key_is_v6,
    input  logic        s_key_valid,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_verdict,
    output logic [2:0]  m_packet_kind,
    output logic [5:0]  m_matched_slot
);

    logic in_accept;
    logic push;
    cmd_t push_cmd;
    logic push_ready;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    // Ready only tracks queue space; frame bytes that produce no command
    // are still held back while full, which keeps the handshake simple.
    assign s_ready   = push_ready;
    assign in_accept = s_valid && s_ready;

    udmf_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .op            (s_op),
        .data_byte     (s_data_byte),
        .last_byte     (s_last_byte),
        .slot          (s_slot),
        .key_addr_high (s_key_addr_high),
        .key_addr_low  (s_key_addr_low),
        .key_port      (s_key_port),
        .key_is_v6     (s_key_is_v6),
        .key_valid     (s_key_valid),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    udmf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    udmf_matcher #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_matcher (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (pop_valid),
        .cmd            (pop_cmd),
        .cmd_pop        (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_packet_kind  (m_packet_kind),
        .m_matched_slot (m_matched_slot)
    );

endmodule
